/* src/irfd_pkg.sv */
// Shared types, register indexes, reset values and helpers of the IR remote frame decoder.
// No dependencies.
package irfd_pkg;

  localparam int NUM_REGS  = 8;
  localparam int REG_W     = 8;
  localparam int REG_IDX_W = 3;
  localparam int CNT_W     = 7;

  localparam logic [REG_IDX_W-1:0] REG_LEADER_MIN = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LEADER_MAX = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEADER_MIN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HEADER_MAX = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_MIN = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_MAX = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ONE_MIN    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_ONE_MAX    = 3'd7;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = {8'd20, 8'd10, 8'd30, 8'd15,
                                     8'd55, 8'd30, 8'd100, 8'd70};

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_VALID  = 2'd1;
  localparam logic [1:0] EV_FAIL   = 2'd2;
  localparam logic [1:0] EV_REPEAT = 2'd3;

  localparam logic [7:0]       TOGGLE_KEY      = 8'd64;
  localparam logic [CNT_W-1:0] FRAME_INTERVALS = 7'd65;
  localparam logic [CNT_W-1:0] FRAME_LAST      = 7'd64;

  typedef struct packed {
    logic leader;
    logic header;
    logic rpt;
  } win_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] key_code;
    logic [7:0] address;
    logic       remote_enabled;
  } res_t;

  function automatic logic in_window(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
    in_window = (v > lo) && (v < hi);
  endfunction

endpackage

/* src/irfd_classify.sv */
// Window classification of one interval against the leader, header and repeat windows.
// Depends on irfd_pkg.
module irfd_classify import irfd_pkg::*; (
  input  logic [7:0] interval,
  input  cfg_regs_t  cfg_regs,
  output win_t       win
);

  always_comb begin
    win.leader = in_window(interval, cfg_regs[REG_LEADER_MIN], cfg_regs[REG_LEADER_MAX]);
    win.header = in_window(interval, cfg_regs[REG_HEADER_MIN], cfg_regs[REG_HEADER_MAX]);
    win.rpt    = in_window(interval, cfg_regs[REG_REPEAT_MIN], cfg_regs[REG_REPEAT_MAX]);
  end

endmodule

/* src/irfd_frame.sv */
// Decoder state, frame bit assembly and result forming for one interval per step.
// Depends on irfd_pkg.
module irfd_frame import irfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] interval,
  input  win_t       win,
  input  logic [7:0] one_min,
  input  logic [7:0] one_max,
  output res_t       res
);

  logic             leader_r, leader_nxt;
  logic             collecting_r, collecting_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic [31:0]      bits_r, bits_nxt;
  logic [7:0]       last_key_r, last_key_nxt;
  logic             en_r, en_nxt;
  logic [7:0]       pair_sum;
  logic             bit_one;
  logic             ok;
  logic             fin;

  assign pair_sum = pend_r + interval;
  assign bit_one  = in_window(pair_sum, one_min, one_max);

  always_comb begin
    leader_nxt     = leader_r;
    collecting_nxt = collecting_r;
    count_nxt      = count_r;
    pend_nxt       = pend_r;
    bits_nxt       = bits_r;
    last_key_nxt   = last_key_r;
    en_nxt         = en_r;
    ok             = 1'b0;
    fin            = 1'b0;
    res.event_res  = EV_NONE;
    res.key_code   = 8'd0;
    res.address    = 8'd0;

    if (win.leader) begin
      leader_nxt = 1'b1;
    end else if (leader_r && win.header) begin
      collecting_nxt = 1'b1;
      leader_nxt     = 1'b0;
      count_nxt      = '0;
      bits_nxt       = '0;
      pend_nxt       = '0;
    end else if (leader_r && win.rpt) begin
      collecting_nxt = 1'b0;
      leader_nxt     = 1'b0;
      res.event_res  = EV_REPEAT;
      res.key_code   = last_key_r;
    end

    if (collecting_nxt) begin
      if (count_nxt[0]) begin
        pend_nxt = interval;
      end else if (count_nxt >= 7'd2) begin
        bits_nxt = {bits_nxt[30:0], bit_one};
      end
      count_nxt = count_nxt + 7'd1;
      if (count_nxt == FRAME_INTERVALS) begin
        fin            = 1'b1;
        ok             = (bits_nxt[31:24] == ~bits_nxt[23:16]) &&
                         (bits_nxt[7:0] == ~bits_nxt[15:8]);
        count_nxt      = '0;
        collecting_nxt = 1'b0;
        res.key_code   = ok ? bits_nxt[15:8] : 8'd0;
        res.event_res  = ok ? EV_VALID : EV_FAIL;
        res.address    = bits_nxt[31:24];
        last_key_nxt   = res.key_code;
        if (res.key_code == TOGGLE_KEY) begin
          en_nxt = ~en_r;
        end
      end
    end

    res.remote_enabled = en_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leader_r     <= 1'b0;
      collecting_r <= 1'b0;
      count_r      <= '0;
      pend_r       <= '0;
      bits_r       <= '0;
      last_key_r   <= '0;
      en_r         <= 1'b1;
    end else if (step_en) begin
      leader_r     <= leader_nxt;
      collecting_r <= collecting_nxt;
      count_r      <= count_nxt;
      pend_r       <= pend_nxt;
      bits_r       <= bits_nxt;
      last_key_r   <= last_key_nxt;
      en_r         <= en_nxt;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FRAME_LAST)
    else $error("interval count ran past the frame length");

  a_collect_count: assert property (@(posedge clk) disable iff (!rst_n)
    collecting_r |-> count_r != 7'd0)
    else $error("collecting with a zero interval count");

  a_flag_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && !(fin && res.key_code == TOGGLE_KEY)) |=> $stable(en_r))
    else $error("enable flag changed without a finished toggle key frame");

endmodule

/* src/ir_remote_frame_decoder.sv */
// IR remote frame decoder top level: input stage, configuration registers, result register.
// Depends on irfd_pkg, irfd_classify and irfd_frame.
// An accepted beat is held in the input stage, then moves to the output register as it advances.
// Throughput: one interval per cycle unless out_ready stalls; state updates once per interval.
// Reset: synchronous active-low; clears state, loads register defaults, empties both stages.
module ir_remote_frame_decoder import irfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_interval,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_event_res,
  output logic [7:0]           out_key_code,
  output logic [7:0]           out_address,
  output logic                 out_remote_enabled,
  input  logic                 cfg_wr_en,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  cfg_regs_t  cfg_r;
  logic       stage_v_r;
  logic [7:0] stage_iv_r;
  logic       out_v_r;
  res_t       out_r;
  res_t       res;
  win_t       win;
  logic       advance;
  logic       accept;

  assign advance  = stage_v_r && (!out_v_r || out_ready);
  assign in_ready = !stage_v_r || advance;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= accept || (stage_v_r && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_iv_r <= in_interval;
    end
  end

  irfd_classify u_classify (
    .interval (stage_iv_r),
    .cfg_regs (cfg_r),
    .win      (win)
  );

  irfd_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (advance),
    .interval (stage_iv_r),
    .win      (win),
    .one_min  (cfg_r[REG_ONE_MIN]),
    .one_max  (cfg_r[REG_ONE_MAX]),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= advance || (out_v_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_event_res      = out_r.event_res;
  assign out_key_code       = out_r.key_code;
  assign out_address        = out_r.address;
  assign out_remote_enabled = out_r.remote_enabled;

  a_fail_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.event_res == EV_FAIL) |-> out_r.key_code == 8'd0)
    else $error("failed frame reported a nonzero key");

  a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.event_res == EV_NONE) |->
      (out_r.key_code == 8'd0 && out_r.address == 8'd0))
    else $error("empty result carried key or address");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !stage_v_r |-> in_ready)
    else $error("input not ready with an empty input stage");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the IR remote frame decoder: a clocked driver and monitor
// around the block, with an in-bench decoder that predicts every result beat.
// Depends on irfd_pkg and ir_remote_frame_decoder.
module tb_top;
  import irfd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_interval = 8'd0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_event_res;
  logic [7:0]           out_key_code;
  logic [7:0]           out_address;
  logic                 out_remote_enabled;
  logic                 cfg_wr_en = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;

  ir_remote_frame_decoder u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_interval        (in_interval),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_key_code       (out_key_code),
    .out_address        (out_address),
    .out_remote_enabled (out_remote_enabled),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [7:0] window_cfg [0:NUM_REGS-1] = '{8'd70, 8'd100, 8'd30, 8'd55,
                                           8'd15, 8'd30, 8'd10, 8'd20};
  logic [7:0] plan_cfg [0:NUM_REGS-1] = '{8'd70, 8'd100, 8'd30, 8'd55,
                                         8'd15, 8'd30, 8'd10, 8'd20};

  logic       armed = 1'b0;
  logic       collecting = 1'b0;
  logic [6:0] pos_count = '0;
  logic [7:0] held_mark = '0;
  logic [31:0] shift_bits = '0;
  logic [7:0] last_key_q = '0;
  logic       enable_q = 1'b1;

  logic [7:0] pending_intervals [$];
  res_t       expected_results [$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_asked = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  logic beat_taken = 1'b0;

  int  cycle_count = 0;
  int  mismatches = 0;
  int  results_seen = 0;
  int  made_count = 0;
  int  valid_frames = 0;
  int  failed_frames = 0;
  int  repeats_seen = 0;
  int  settings_used = 1;

  function automatic logic strictly_between(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
    return (v > lo) && (v < hi);
  endfunction

  function automatic void decode_interval(input logic [7:0] v, output res_t r);
    logic [7:0] sum;
    logic [6:0] idx;
    logic       ok;
    r = '0;
    r.event_res = EV_NONE;
    if (strictly_between(v, window_cfg[REG_LEADER_MIN], window_cfg[REG_LEADER_MAX])) begin
      armed = 1'b1;
    end else if (armed &&
                 strictly_between(v, window_cfg[REG_HEADER_MIN], window_cfg[REG_HEADER_MAX])) begin
      collecting = 1'b1;
      armed = 1'b0;
      pos_count = '0;
      shift_bits = '0;
      held_mark = '0;
    end else if (armed &&
                 strictly_between(v, window_cfg[REG_REPEAT_MIN], window_cfg[REG_REPEAT_MAX])) begin
      collecting = 1'b0;
      armed = 1'b0;
      r.event_res = EV_REPEAT;
      r.key_code = last_key_q;
    end
    if (collecting) begin
      idx = pos_count;
      if (idx[0]) begin
        held_mark = v;
      end else if (idx >= 7'd2) begin
        sum = held_mark + v;
        shift_bits = {shift_bits[30:0],
                      strictly_between(sum, window_cfg[REG_ONE_MIN], window_cfg[REG_ONE_MAX])};
      end
      pos_count = idx + 7'd1;
      if (pos_count == FRAME_INTERVALS) begin
        ok = (shift_bits[31:24] == ~shift_bits[23:16]) && (shift_bits[7:0] == ~shift_bits[15:8]);
        pos_count = '0;
        collecting = 1'b0;
        r.key_code = ok ? shift_bits[15:8] : 8'd0;
        r.event_res = ok ? EV_VALID : EV_FAIL;
        r.address = shift_bits[31:24];
        last_key_q = r.key_code;
        if (r.key_code == TOGGLE_KEY) begin
          enable_q = ~enable_q;
        end
      end
    end
    r.remote_enabled = enable_q;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %0s got %0d expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch_beats
    res_t want;
    cycle_count++;
    if (rst_n) begin
      if (cfg_wr_en) begin
        window_cfg[cfg_index] = cfg_data;
      end
      if (in_valid && in_ready) begin
        decode_interval(in_interval, want);
        expected_results.push_back(want);
        beat_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing pending, event", out_event_res, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_event_res != want.event_res)
            report_mismatch("event_res", out_event_res, want.event_res);
          if (out_key_code != want.key_code)
            report_mismatch("key_code", out_key_code, want.key_code);
          if (out_address != want.address)
            report_mismatch("address", out_address, want.address);
          if (out_remote_enabled != want.remote_enabled)
            report_mismatch("remote_enabled", out_remote_enabled, want.remote_enabled);
          if (want.event_res == EV_VALID) valid_frames++;
          if (want.event_res == EV_FAIL) failed_frames++;
          if (want.event_res == EV_REPEAT) repeats_seen++;
        end
      end
    end
  end

  always @(negedge clk) begin : drive_intervals
    logic       nxt_valid;
    logic [7:0] nxt_data;
    nxt_valid = in_valid;
    nxt_data = in_interval;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && beat_taken) begin
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_intervals.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        nxt_valid = 1'b1;
        nxt_data = pending_intervals.pop_front();
      end
    end
    beat_taken = 1'b0;
    in_valid <= nxt_valid;
    in_interval <= nxt_data;
  end

  always @(negedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_asked != hold_served) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic void queue_interval(logic [7:0] v);
    pending_intervals.push_back(v);
    made_count++;
  endfunction

  function automatic logic [7:0] pick_in(logic [7:0] lo, logic [7:0] hi);
    if (hi > lo + 8'd1) return 8'($urandom_range(int'(lo) + 1, int'(hi) - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] frame_word();
    logic [7:0] a, na, c, nc;
    a = 8'($urandom_range(0, 255));
    na = ~a;
    if ($urandom_range(0, 9) == 0) na = 8'($urandom_range(0, 255));
    c = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 6) == 0) c = TOGGLE_KEY;
    nc = ~c;
    if ($urandom_range(0, 9) == 0) nc = 8'($urandom_range(0, 255));
    return {a, na, c, nc};
  endfunction

  task automatic queue_frame(input int n_data, input bit inject);
    logic [31:0] bits;
    logic [7:0]  data [0:63];
    logic [7:0]  m, s, t;
    int          k, tries;
    bits = frame_word();
    queue_interval(pick_in(plan_cfg[REG_LEADER_MIN], plan_cfg[REG_LEADER_MAX]));
    queue_interval(pick_in(plan_cfg[REG_HEADER_MIN], plan_cfg[REG_HEADER_MAX]));
    for (k = 0; k < 32; k++) begin
      for (tries = 0; tries < 8; tries++) begin
        m = 8'($urandom_range(0, 255));
        if (bits[31-k]) begin
          t = pick_in(plan_cfg[REG_ONE_MIN], plan_cfg[REG_ONE_MAX]);
          s = t - m;
        end else begin
          s = 8'($urandom_range(0, 255));
        end
        t = m + s;
        if (!strictly_between(m, plan_cfg[REG_LEADER_MIN], plan_cfg[REG_LEADER_MAX]) &&
            !strictly_between(s, plan_cfg[REG_LEADER_MIN], plan_cfg[REG_LEADER_MAX]) &&
            strictly_between(t, plan_cfg[REG_ONE_MIN], plan_cfg[REG_ONE_MAX]) == bits[31-k])
          break;
      end
      data[2*k] = m;
      data[2*k+1] = s;
    end
    if (inject) begin
      data[$urandom_range(0, 63)] = pick_in(plan_cfg[REG_LEADER_MIN], plan_cfg[REG_LEADER_MAX]);
    end
    for (k = 0; k < n_data; k++) begin
      queue_interval(data[k]);
    end
  endtask

  task automatic queue_repeat();
    queue_interval(pick_in(plan_cfg[REG_LEADER_MIN], plan_cfg[REG_LEADER_MAX]));
    queue_interval(pick_in(plan_cfg[REG_REPEAT_MIN], plan_cfg[REG_REPEAT_MAX]));
  endtask

  task automatic make_traffic(input int n_items);
    int goal, r, k;
    goal = made_count + n_items;
    while (made_count < goal) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        queue_frame(64, 1'b0);
      end else if (r < 60) begin
        queue_frame(64, 1'b1);
      end else if (r < 72) begin
        queue_repeat();
      end else if (r < 82) begin
        queue_frame($urandom_range(1, 63), 1'b0);
        if ($urandom_range(0, 1) == 1) queue_repeat();
      end else begin
        for (k = $urandom_range(1, 4); k > 0; k--) begin
          queue_interval(8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  task automatic write_plan();
    int i;
    for (i = 0; i < NUM_REGS; i++) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_IDX_W'(i);
      cfg_data <= plan_cfg[i];
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained();
    while (pending_intervals.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : run_test
    int i;
    logic [7:0] directed [$];
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 22;
    recv_idle_pct = 68;
    directed = '{8'd0, 8'd255, 8'd70, 8'd100, 8'd71, 8'd30, 8'd29, 8'd99, 8'd16, 8'd16,
                 8'd80, 8'd31, 8'd5, 8'd80, 8'd40, 8'd5, 8'd6, 8'd80, 8'd20, 8'd80,
                 8'd54, 8'd255, 8'd0, 8'd128, 8'd127};
    foreach (directed[i]) queue_interval(directed[i]);
    make_traffic(300);
    wait_drained();

    for (i = 0; i < NUM_REGS; i++) plan_cfg[i] = 8'd0;
    write_plan();
    make_traffic(50);
    wait_drained();

    for (i = 0; i < NUM_REGS; i++) plan_cfg[i] = 8'd255;
    write_plan();
    make_traffic(50);
    wait_drained();

    for (i = 0; i < NUM_REGS; i++) plan_cfg[i] = (i % 2 == 0) ? 8'd0 : 8'd255;
    write_plan();
    make_traffic(50);
    wait_drained();

    send_idle_pct = 68;
    recv_idle_pct = 22;
    plan_cfg[REG_LEADER_MIN] = 8'($urandom_range(60, 150));
    plan_cfg[REG_LEADER_MAX] = 8'(int'(plan_cfg[REG_LEADER_MIN]) + $urandom_range(2, 60));
    plan_cfg[REG_HEADER_MIN] = 8'($urandom_range(25, 50));
    plan_cfg[REG_HEADER_MAX] = 8'(int'(plan_cfg[REG_HEADER_MIN]) + $urandom_range(2, 20));
    plan_cfg[REG_REPEAT_MIN] = 8'($urandom_range(5, 20));
    plan_cfg[REG_REPEAT_MAX] = 8'(int'(plan_cfg[REG_REPEAT_MIN]) + $urandom_range(2, 12));
    plan_cfg[REG_ONE_MIN] = 8'($urandom_range(0, 30));
    plan_cfg[REG_ONE_MAX] = 8'(int'(plan_cfg[REG_ONE_MIN]) + $urandom_range(2, 40));
    write_plan();
    make_traffic(350);
    wait_drained();

    for (i = 0; i < NUM_REGS; i++) plan_cfg[i] = 8'($urandom_range(0, 255));
    write_plan();
    make_traffic(150);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    plan_cfg = '{8'd70, 8'd100, 8'd30, 8'd55, 8'd15, 8'd30, 8'd10, 8'd20};
    write_plan();
    make_traffic(300);
    hold_asked++;
    wait_drained();
    repeat (8) @(negedge clk);

    if (expected_results.size() != 0)
      report_mismatch("results still pending at end, count", expected_results.size(), 0);
    $display("Decoded %0d intervals under %0d register settings, %0d result beats checked.",
             made_count, settings_used, results_seen);
    $display("Frames accepted %0d, frames failing the check %0d, repeat codes %0d.",
             valid_frames, failed_frames, repeats_seen);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("TB_ERROR");
    $finish;
  end

endmodule
